@@ rtl/twec_pkg.sv @@
// Shared request and response types, command codes and queue depths for the embedding cache.
`timescale 1ns / 1ps

package twec_pkg;

  typedef struct packed {
    logic        cmd;
    logic [31:0] key;
    logic [3:0]  word_index;
    logic [31:0] fill_word;
  } twec_req_t;

  typedef struct packed {
    logic        hit;
    logic [31:0] data_word;
    logic [3:0]  out_index;
    logic        last;
  } twec_rsp_t;

  localparam logic CMD_LOOKUP = 1'b0;
  localparam logic CMD_FILL   = 1'b1;

  localparam int REQ_QUEUE_DEPTH = 2;
  localparam int RSP_QUEUE_DEPTH = 3;

endpackage

@@ rtl/two_way_embedding_cache_core.sv @@
// Two-way set-associative embedding cache: front end and back end joined by a request queue.
// A miss is answered by a single response and a hit by its vector, streamed word by word. A NUM_SETS
// that is not a power of two adds a remainder pass in the front end, which then takes no request.
// The back end takes no new request until the current one is done; a hit streams through the one
// word per cycle read port of the vector memory, held by rsp_ready stalls and a full response queue.
// After reset a clearing pass over every set zeroes valid and recent-way bits while req_ready stays low.
`timescale 1ns / 1ps

module two_way_embedding_cache_core #(
  parameter int NUM_SETS  = 256,
  parameter int EMB_DIM   = 16,
  parameter int KEY_BITS  = 32,
  parameter int WORD_BITS = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  input  twec_pkg::twec_req_t req,
  output logic                rsp_valid,
  input  logic                rsp_ready,
  output twec_pkg::twec_rsp_t rsp
);

  import twec_pkg::*;

  localparam int KEY_W   = (KEY_BITS < 32) ? KEY_BITS : 32;
  localparam int WORD_W  = (WORD_BITS < 32) ? WORD_BITS : 32;
  localparam int SET_W   = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
  localparam int ENTRY_W = SET_W + $bits(twec_req_t);

  logic               clearing;
  logic               q_valid;
  logic               q_ready;
  logic [ENTRY_W-1:0] q_data;

  twec_front #(
    .NUM_SETS (NUM_SETS),
    .EMB_DIM  (EMB_DIM),
    .KEY_W    (KEY_W),
    .WORD_W   (WORD_W)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .clearing  (clearing),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_data    (q_data)
  );

  twec_back #(
    .NUM_SETS (NUM_SETS),
    .EMB_DIM  (EMB_DIM),
    .KEY_W    (KEY_W),
    .WORD_W   (WORD_W)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .clearing  (clearing),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_data    (q_data),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule

@@ rtl/twec_ram.sv @@
// Generic simple dual-port RAM with one write port and one registered read port.
`timescale 1ns / 1ps

module twec_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/twec_queue.sv @@
// Small register FIFO with valid/ready on both sides and an occupancy count.
`timescale 1ns / 1ps

module twec_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2,
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data,
  output logic [CNT_W-1:0] count
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (!do_push && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

@@ rtl/twec_front.sv @@
// Request front end: accepts requests, drops out-of-range fill words, finds the set and queues.
`timescale 1ns / 1ps

module twec_front #(
  parameter int NUM_SETS = 256,
  parameter int EMB_DIM  = 16,
  parameter int KEY_W    = 32,
  parameter int WORD_W   = 32,
  localparam int SET_W   = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1,
  localparam int ENTRY_W = SET_W + $bits(twec_pkg::twec_req_t)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   clearing,
  input  logic                   req_valid,
  output logic                   req_ready,
  input  twec_pkg::twec_req_t    req,
  output logic                   q_valid,
  input  logic                   q_ready,
  output logic [ENTRY_W-1:0]     q_data
);

  import twec_pkg::*;

  localparam logic [31:0] KEY_MASK  = 32'((64'h1 << KEY_W) - 64'h1);
  localparam logic [31:0] WORD_MASK = 32'((64'h1 << WORD_W) - 64'h1);
  localparam bit          POW2      = ((NUM_SETS & (NUM_SETS - 1)) == 0);

  twec_req_t    req_m;
  logic         keep;
  logic         push_valid;
  logic         push_ready;
  logic [ENTRY_W-1:0] push_data;

  always_comb begin
    req_m           = req;
    req_m.key       = req.key & KEY_MASK;
    req_m.fill_word = req.fill_word & WORD_MASK;
  end

  assign keep = (req.cmd == CMD_LOOKUP) || (32'(req.word_index) < 32'(EMB_DIM));

  generate
    if (POW2) begin : g_mask
      logic [31:0] set_full;

      assign set_full   = req_m.key & 32'(NUM_SETS - 1);
      assign req_ready  = push_ready && !clearing;
      assign push_valid = req_valid && !clearing && keep;
      assign push_data  = {set_full[SET_W-1:0], req_m};
    end else begin : g_mod
      localparam int KEY_PAD = KEY_W + (KEY_W % 2);
      localparam int STEPS   = KEY_PAD / 2;
      localparam int STEP_W  = (STEPS > 1) ? $clog2(STEPS) : 1;
      localparam int R_W     = SET_W + 2;
      localparam logic [R_W-1:0] N1 = R_W'(NUM_SETS);
      localparam logic [R_W-1:0] N2 = R_W'(2 * NUM_SETS);
      localparam logic [R_W-1:0] N3 = R_W'(3 * NUM_SETS);

      typedef enum logic [1:0] {IDLE, CALC, PUSH} state_t;

      state_t             state;
      twec_req_t          hold;
      logic [KEY_PAD-1:0] shreg;
      logic [SET_W-1:0]   rem;
      logic [STEP_W-1:0]  step;
      logic [R_W-1:0]     r;
      logic [R_W-1:0]     r_red;

      assign r = {rem, shreg[KEY_PAD-1 -: 2]};

      always_comb begin
        if (r >= N3) begin
          r_red = r - N3;
        end else if (r >= N2) begin
          r_red = r - N2;
        end else if (r >= N1) begin
          r_red = r - N1;
        end else begin
          r_red = r;
        end
      end

      assign req_ready  = (state == IDLE) && !clearing;
      assign push_valid = (state == PUSH);
      assign push_data  = {rem, hold};

      always_ff @(posedge clk) begin
        if (rst) begin
          state <= IDLE;
        end else begin
          case (state)
            IDLE: begin
              if (req_valid && req_ready && keep) begin
                hold  <= req_m;
                shreg <= KEY_PAD'(req_m.key[KEY_W-1:0]);
                rem   <= '0;
                step  <= '0;
                state <= CALC;
              end
            end
            CALC: begin
              rem   <= r_red[SET_W-1:0];
              shreg <= shreg << 2;
              step  <= step + 1'b1;
              if (step == STEP_W'(STEPS - 1)) begin
                state <= PUSH;
              end
            end
            PUSH: begin
              if (push_ready) begin
                state <= IDLE;
              end
            end
            default: begin
              state <= IDLE;
            end
          endcase
        end
      end
    end
  endgenerate

  twec_queue #(
    .WIDTH (ENTRY_W),
    .DEPTH (REQ_QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_data),
    .count      ()
  );

endmodule

@@ rtl/twec_back.sv @@
// Back end: tag and set-state lookup, fill writes, vector streaming and the response queue.
`timescale 1ns / 1ps

module twec_back #(
  parameter int NUM_SETS = 256,
  parameter int EMB_DIM  = 16,
  parameter int KEY_W    = 32,
  parameter int WORD_W   = 32,
  localparam int SET_W   = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1,
  localparam int ENTRY_W = SET_W + $bits(twec_pkg::twec_req_t)
) (
  input  logic                 clk,
  input  logic                 rst,
  output logic                 clearing,
  input  logic                 q_valid,
  output logic                 q_ready,
  input  logic [ENTRY_W-1:0]   q_data,
  output logic                 rsp_valid,
  input  logic                 rsp_ready,
  output twec_pkg::twec_rsp_t  rsp
);

  import twec_pkg::*;

  localparam int VDEPTH = 2 * NUM_SETS * EMB_DIM;
  localparam int VA_W   = (VDEPTH > 1) ? $clog2(VDEPTH) : 1;
  localparam int KW     = (EMB_DIM > 1) ? $clog2(EMB_DIM) : 1;
  localparam int REQ_W  = $bits(twec_req_t);
  localparam int OCNT_W = $clog2(RSP_QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {CLEAR, IDLE, EXEC, STREAM} state_t;

  state_t           state;
  logic [SET_W-1:0] clr_cnt;
  twec_req_t        cur_req;
  logic [SET_W-1:0] cur_set;
  logic             fill_victim;
  logic [VA_W-1:0]  vbase;
  logic [KW-1:0]    k;
  logic             rd_pending;
  logic [KW-1:0]    rd_k;

  twec_req_t        q_req;
  logic [SET_W-1:0] q_set;
  logic [SET_W-1:0] rd_set;

  logic [2:0]        meta_r;
  logic              meta_we;
  logic [SET_W-1:0]  meta_waddr;
  logic [2:0]        meta_wdata;
  logic [KEY_W-1:0]  tag0_r;
  logic [KEY_W-1:0]  tag1_r;
  logic              tag0_we;
  logic              tag1_we;
  logic [WORD_W-1:0] vec_r;
  logic              vec_we;
  logic [VA_W-1:0]   vec_waddr;
  logic [VA_W-1:0]   vec_raddr;

  logic        is_fill;
  logic        h0;
  logic        h1;
  logic        is_hit;
  logic        hit_way;
  logic        first_word;
  logic        last_word;
  logic        victim;
  logic        way;
  logic [31:0] row_base;
  logic [31:0] fill_addr;
  logic [31:0] rd_addr;
  logic [1:0]  v_fill;
  logic        miss_push;
  logic        issue;
  logic        k_last;

  logic              o_valid;
  logic              o_ready;
  twec_rsp_t         o_data;
  logic [OCNT_W-1:0] o_count;
  logic [31:0]       idx32;

  assign q_req    = twec_req_t'(q_data[REQ_W-1:0]);
  assign q_set    = q_data[REQ_W +: SET_W];
  assign q_ready  = (state == IDLE);
  assign clearing = (state == CLEAR);
  assign rd_set   = (state == IDLE) ? q_set : cur_set;

  assign is_fill    = (cur_req.cmd == CMD_FILL);
  assign h0         = meta_r[0] && (tag0_r == cur_req.key[KEY_W-1:0]);
  assign h1         = meta_r[1] && (tag1_r == cur_req.key[KEY_W-1:0]);
  assign is_hit     = h0 || h1;
  assign hit_way    = !h0;
  assign first_word = (cur_req.word_index == 4'd0);
  assign last_word  = (32'(cur_req.word_index) == 32'(EMB_DIM - 1));
  assign victim     = first_word ? !meta_r[2] : fill_victim;
  assign way        = is_fill ? victim : hit_way;
  assign row_base   = 32'({cur_set, way}) * 32'(EMB_DIM);
  assign fill_addr  = row_base + 32'(cur_req.word_index);
  assign vec_waddr  = fill_addr[VA_W-1:0];
  assign vec_we     = (state == EXEC) && is_fill;
  assign rd_addr    = 32'(vbase) + 32'(k);
  assign vec_raddr  = rd_addr[VA_W-1:0];
  assign tag0_we    = vec_we && last_word && !victim;
  assign tag1_we    = vec_we && last_word && victim;

  assign miss_push = (state == EXEC) && !is_fill && !is_hit && o_ready && !rd_pending;
  assign issue     = (state == STREAM)
                     && ((32'(o_count) + 32'(rd_pending)) < 32'(RSP_QUEUE_DEPTH));
  assign k_last    = (32'(k) == 32'(EMB_DIM - 1));

  always_comb begin
    v_fill = meta_r[1:0];
    if (first_word) begin
      v_fill[victim] = 1'b0;
    end
    if (last_word) begin
      v_fill[victim] = 1'b1;
    end
  end

  always_comb begin
    meta_we    = 1'b0;
    meta_waddr = cur_set;
    meta_wdata = '0;
    case (state)
      CLEAR: begin
        meta_we    = 1'b1;
        meta_waddr = clr_cnt;
      end
      EXEC: begin
        if (is_fill) begin
          meta_we    = first_word || last_word;
          meta_wdata = {last_word ? victim : meta_r[2], v_fill};
        end else if (is_hit) begin
          meta_we    = 1'b1;
          meta_wdata = {hit_way, meta_r[1:0]};
        end
      end
      default: begin
        meta_we = 1'b0;
      end
    endcase
  end

  assign idx32   = 32'(rd_k);
  assign o_valid = rd_pending || miss_push;

  always_comb begin
    if (rd_pending) begin
      o_data.hit       = 1'b1;
      o_data.data_word = 32'(vec_r);
      o_data.out_index = idx32[3:0];
      o_data.last      = (idx32 == 32'(EMB_DIM - 1));
    end else begin
      o_data.hit       = 1'b0;
      o_data.data_word = '0;
      o_data.out_index = '0;
      o_data.last      = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= CLEAR;
      clr_cnt     <= '0;
      fill_victim <= 1'b0;
      rd_pending  <= 1'b0;
      k           <= '0;
    end else begin
      rd_pending <= issue;
      rd_k       <= k;
      case (state)
        CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == SET_W'(NUM_SETS - 1)) begin
            state <= IDLE;
          end
        end
        IDLE: begin
          if (q_valid) begin
            cur_req <= q_req;
            cur_set <= q_set;
            state   <= EXEC;
          end
        end
        EXEC: begin
          if (is_fill) begin
            if (first_word) begin
              fill_victim <= victim;
            end
            state <= IDLE;
          end else if (is_hit) begin
            vbase <= row_base[VA_W-1:0];
            k     <= '0;
            state <= STREAM;
          end else if (miss_push) begin
            state <= IDLE;
          end
        end
        STREAM: begin
          if (issue) begin
            k <= k + 1'b1;
            if (k_last) begin
              state <= IDLE;
            end
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  twec_ram #(
    .WIDTH (3),
    .DEPTH (NUM_SETS)
  ) u_meta (
    .clk   (clk),
    .we    (meta_we),
    .waddr (meta_waddr),
    .wdata (meta_wdata),
    .raddr (rd_set),
    .rdata (meta_r)
  );

  twec_ram #(
    .WIDTH (KEY_W),
    .DEPTH (NUM_SETS)
  ) u_tag0 (
    .clk   (clk),
    .we    (tag0_we),
    .waddr (cur_set),
    .wdata (cur_req.key[KEY_W-1:0]),
    .raddr (rd_set),
    .rdata (tag0_r)
  );

  twec_ram #(
    .WIDTH (KEY_W),
    .DEPTH (NUM_SETS)
  ) u_tag1 (
    .clk   (clk),
    .we    (tag1_we),
    .waddr (cur_set),
    .wdata (cur_req.key[KEY_W-1:0]),
    .raddr (rd_set),
    .rdata (tag1_r)
  );

  twec_ram #(
    .WIDTH (WORD_W),
    .DEPTH (VDEPTH)
  ) u_vec (
    .clk   (clk),
    .we    (vec_we),
    .waddr (vec_waddr),
    .wdata (cur_req.fill_word[WORD_W-1:0]),
    .raddr (vec_raddr),
    .rdata (vec_r)
  );

  twec_queue #(
    .WIDTH ($bits(twec_rsp_t)),
    .DEPTH (RSP_QUEUE_DEPTH)
  ) u_rsp_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (o_valid),
    .push_ready (o_ready),
    .push_data  (o_data),
    .pop_valid  (rsp_valid),
    .pop_ready  (rsp_ready),
    .pop_data   (rsp),
    .count      (o_count)
  );

endmodule

@@ dv/two_way_embedding_cache_core_tb.sv @@
// Self-checking testbench for the two-way embedding cache core: lookups, fills and LRU replacement.
`timescale 1ns / 1ps

module two_way_embedding_cache_core_tb;
  import twec_pkg::*;

  localparam int NSETS = 256;
  localparam int EDIM = 16;
  localparam int CYCLE_LIMIT = 300000;
  localparam int DRAIN_CYCLES = 40;
  localparam int POOL_SIZE = 8;

  localparam int RX_FREE = 0;
  localparam int RX_LIGHT = 1;
  localparam int RX_HEAVY = 2;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  twec_req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  twec_rsp_t rsp;

  two_way_embedding_cache_core DUT (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp(rsp)
  );

  bit [31:0] tag_shadow [2*NSETS];
  bit valid_shadow [2*NSETS];
  bit recent_shadow [NSETS];
  bit [31:0] vector_shadow [2*NSETS*EDIM];
  bit fill_way;

  twec_req_t pending_reqs[$];
  twec_rsp_t expected_rsps[$];
  twec_rsp_t want;
  logic [31:0] key_pool [POOL_SIZE];
  logic [31:0] last_fill_key;

  int queued_reqs = 0;
  int lookup_hits = 0;
  int lookup_misses = 0;
  int dual_matches = 0;
  int fill_words = 0;
  int rsps_checked = 0;
  int mismatches = 0;
  int cycle_count = 0;
  int gap_left = 0;
  int burst_left = 0;
  int rx_mode = RX_FREE;
  int rx_left = 0;
  bit req_taken = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic void predict_response(twec_req_t r);
    int set_idx;
    int base;
    int way;
    int widx;
    twec_rsp_t o;
    set_idx = int'(r.key % NSETS);
    base = 2 * set_idx;
    if (r.cmd == CMD_LOOKUP) begin
      way = -1;
      for (int w = 1; w >= 0; w--) begin
        if (valid_shadow[base + w] && tag_shadow[base + w] == r.key) way = w;
      end
      if (valid_shadow[base] && valid_shadow[base + 1] &&
          tag_shadow[base] == r.key && tag_shadow[base + 1] == r.key) dual_matches++;
      if (way < 0) begin
        o = '0;
        o.last = 1'b1;
        expected_rsps.insert(expected_rsps.size(), o);
        lookup_misses++;
      end else begin
        recent_shadow[set_idx] = way[0];
        for (int k = 0; k < EDIM; k++) begin
          o.hit = 1'b1;
          o.data_word = vector_shadow[(base + way) * EDIM + k];
          o.out_index = 4'(k);
          o.last = (k == EDIM - 1);
          expected_rsps.insert(expected_rsps.size(), o);
        end
        lookup_hits++;
      end
    end else begin
      fill_words++;
      widx = int'(r.word_index);
      if (widx < EDIM) begin
        // Word 0 picks the victim and hides it until the last word lands.
        if (widx == 0) begin
          fill_way = ~recent_shadow[set_idx];
          valid_shadow[base + fill_way] = 1'b0;
        end
        vector_shadow[(base + fill_way) * EDIM + widx] = r.fill_word;
        if (widx == EDIM - 1) begin
          tag_shadow[base + fill_way] = r.key;
          valid_shadow[base + fill_way] = 1'b1;
          recent_shadow[set_idx] = fill_way;
        end
      end
    end
  endfunction

  function automatic logic [31:0] random_word();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return 32'h0000_0000;
    if (pick == 1) return 32'hFFFF_FFFF;
    return $urandom;
  endfunction

  function automatic logic [31:0] pick_key();
    return key_pool[$urandom_range(0, POOL_SIZE - 1)];
  endfunction

  function automatic void queue_req(logic cmd, logic [31:0] key, logic [3:0] idx,
                                    logic [31:0] word);
    twec_req_t r;
    r.cmd = cmd;
    r.key = key;
    r.word_index = idx;
    r.fill_word = word;
    pending_reqs.insert(pending_reqs.size(), r);
    queued_reqs++;
  endfunction

  function automatic void queue_lookup(logic [31:0] key);
    queue_req(CMD_LOOKUP, key, 4'($urandom), $urandom);
  endfunction

  // Word 0 goes first and the last word last, so a completed entry never holds an unwritten word.
  function automatic void queue_full_fill(logic [31:0] key);
    int order [EDIM];
    int j;
    int tmp;
    for (int i = 0; i < EDIM; i++) order[i] = i;
    for (int i = EDIM - 2; i > 1; i--) begin
      j = $urandom_range(1, i);
      tmp = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    for (int i = 0; i < EDIM; i++) begin
      queue_req(CMD_FILL, key, 4'(order[i]), random_word());
      if (i < EDIM - 1 && $urandom_range(0, 99) < 15) queue_lookup(pick_key());
    end
    last_fill_key = key;
  endfunction

  function automatic void queue_random_mix(int target);
    int kind;
    int stop;
    logic [31:0] key;
    while (queued_reqs < target) begin
      kind = $urandom_range(0, 99);
      if (kind < 40) begin
        queue_full_fill(($urandom_range(0, 2) == 0) ? last_fill_key : pick_key());
      end else if (kind < 80) begin
        repeat ($urandom_range(1, 4)) begin
          queue_lookup(($urandom_range(0, 6) == 0) ? $urandom : pick_key());
        end
      end else if (kind < 90) begin
        // An abandoned fill leaves its victim invalid.
        key = pick_key();
        stop = $urandom_range(0, EDIM - 2);
        for (int i = 0; i <= stop; i++) queue_req(CMD_FILL, key, 4'(i), random_word());
      end else begin
        // Stray words without a word 0 overwrite the way latched by the previous fill.
        repeat ($urandom_range(1, 3)) begin
          queue_req(CMD_FILL, pick_key(), 4'($urandom_range(1, EDIM - 2)), random_word());
        end
      end
    end
  endfunction

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || expected_rsps.size() != 0) @(posedge clk);
  endtask

  always @(negedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!req_valid || req_taken) begin
      if (gap_left > 0) begin
        gap_left--;
        req_valid <= 1'b0;
      end else if (pending_reqs.size() != 0) begin
        req_valid <= 1'b1;
        req <= pending_reqs[0];
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 24);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
        end
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_left = $urandom_range(16, 80);
      rx_mode = $urandom_range(RX_FREE, RX_HEAVY);
    end
    rx_left--;
    case (rx_mode)
      RX_FREE: begin
        rsp_ready <= 1'b1;
      end
      RX_LIGHT: begin
        rsp_ready <= ($urandom_range(0, 3) != 0);
      end
      default: begin
        rsp_ready <= ($urandom_range(0, 3) == 0);
      end
    endcase
  end

  always @(posedge clk) begin
    req_taken = !rst && req_valid && req_ready;
    if (req_taken) begin
      predict_response(req);
      void'(pending_reqs.pop_front());
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) begin
      if (expected_rsps.size() == 0) begin
        $error("Unexpected response: hit=%0d data_word=%h out_index=%0d last=%0d",
               rsp.hit, rsp.data_word, rsp.out_index, rsp.last);
        mismatches++;
      end else begin
        want = expected_rsps.pop_front();
        rsps_checked++;
        if (rsp.hit !== want.hit) begin
          $error("hit: expected %0d, got %0d", want.hit, rsp.hit);
          mismatches++;
        end
        if (rsp.data_word !== want.data_word) begin
          $error("data_word: expected %h, got %h", want.data_word, rsp.data_word);
          mismatches++;
        end
        if (rsp.out_index !== want.out_index) begin
          $error("out_index: expected %0d, got %0d", want.out_index, rsp.out_index);
          mismatches++;
        end
        if (rsp.last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, rsp.last);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d responses outstanding.",
               cycle_count, expected_rsps.size());
      $display("two_way_embedding_cache_core test failed");
      $finish;
    end
  end

  initial begin
    key_pool[0] = 32'h0000_0000;
    key_pool[1] = 32'hFFFF_FFFF;
    key_pool[2] = {24'($urandom), 8'hFF};
    key_pool[3] = {24'($urandom), 8'h00};
    key_pool[4] = {24'($urandom), 8'hFF};
    key_pool[5] = {24'($urandom), 8'h5C};
    key_pool[6] = {24'($urandom), 8'h5C};
    key_pool[7] = $urandom;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    queue_lookup(32'h0000_0000);
    queue_lookup(32'hFFFF_FFFF);
    for (int i = 0; i < EDIM; i++) begin
      queue_req(CMD_FILL, 32'hFFFF_FFFF, 4'(i),
                (i % 3 == 0) ? 32'h0000_0000 :
                (i % 3 == 1) ? 32'hFFFF_FFFF : (32'h5A5A_0000 | i));
    end
    last_fill_key = 32'hFFFF_FFFF;
    queue_lookup(32'hFFFF_FFFF);
    queue_lookup(32'h0000_00FF);
    queue_lookup(32'h0000_0000);
    wait_drained();

    // Refilling the same key puts it in both ways, and way 0 must answer.
    queue_full_fill(last_fill_key);
    queue_lookup(last_fill_key);
    queue_random_mix(70);
    wait_drained();
    queue_random_mix(115);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d requests: %0d lookup hits, %0d lookup misses, %0d with both ways holding",
             queued_reqs, lookup_hits, lookup_misses, dual_matches);
    $display("the key, %0d fill words; %0d responses checked, %0d mismatches.",
             fill_words, rsps_checked, mismatches);
    if (mismatches == 0) begin
      $display("two_way_embedding_cache_core test passed");
    end else begin
      $display("two_way_embedding_cache_core test failed");
    end
    $finish;
  end

endmodule
